### rtl/scbp_pkg.sv
`timescale 1ns / 1ps

package scbp_pkg;

    // Default geometry of the column bitmap.
    localparam int WORD_BITS_DEF = 64;
    localparam int MAX_WORDS_DEF = 64;

    // Depth of the command queue between front and back.
    localparam int QUEUE_DEPTH_DEF = 4;

    // Fixed widths of the result fields.
    localparam int POS_W   = 6;
    localparam int DATA_W  = 64;
    localparam int COUNT_W = 7;

    // Width of the rows_in_use register.
    localparam int ROWS_W = 13;

    // Register map: index of each configuration register.
    localparam logic REG_ROWS_IN_USE = 1'b0;

    // Item kinds on the input stream.
    localparam logic [1:0] KIND_ENTRY       = 2'd0;
    localparam logic [1:0] KIND_ENTRY_CLOSE = 2'd1;
    localparam logic [1:0] KIND_CLOSE       = 2'd2;

    // One classified command handed from the front to the back.
    typedef struct packed {
        logic             entry;
        logic             close;
        logic [POS_W-1:0] word;
        logic [POS_W-1:0] bit_pos;
    } cmd_t;

    // Back-end sequencer states.
    typedef enum logic [1:0] {
        ST_RUN,
        ST_CLOSE,
        ST_DRAIN
    } state_t;

endpackage

### rtl/scbp_queue.sv
`timescale 1ns / 1ps

module scbp_queue #(
    parameter int DEPTH = scbp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  scbp_pkg::cmd_t      push_cmd,
    output logic                full,
    input  logic                pop,
    output scbp_pkg::cmd_t      pop_cmd,
    output logic                nonempty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    scbp_pkg::cmd_t    slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign nonempty = (count_reg != '0);
    assign pop_cmd  = slot_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### rtl/scbp_front.sv
`timescale 1ns / 1ps

module scbp_front #(
    parameter int WORD_BITS = scbp_pkg::WORD_BITS_DEF,
    parameter int MAX_WORDS = scbp_pkg::MAX_WORDS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [scbp_pkg::ROWS_W-1:0] rows_in_use,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  kind,
    input  logic [15:0]                 row_index,
    output logic                        push,
    output scbp_pkg::cmd_t              push_cmd,
    input  logic                        queue_full
);

    localparam int CAP         = MAX_WORDS * WORD_BITS;
    localparam int ROW_W       = $clog2(CAP);
    localparam int WW          = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int BW          = $clog2(WORD_BITS);
    localparam int RECIP_SHIFT = ROW_W + 1;
    localparam int RECIP       = (1 << RECIP_SHIFT) / WORD_BITS;
    localparam int PROD_W      = ROW_W + RECIP_SHIFT;

    logic              accept;
    logic              row_ok;
    logic              is_entry;
    logic              is_close;
    logic [PROD_W-1:0] prod;
    logic              advance;

    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic              s1_entry_reg;
    logic              s1_close_reg;
    logic [ROW_W-1:0]  s1_row_reg;
    logic [WW-1:0]     s1_quot_reg;

    logic [ROW_W:0]    rem_raw;
    logic              rem_over;
    logic [WW-1:0]     word_fix;
    logic [ROW_W:0]    bit_fix;

    // Classify the incoming item: which rows land in the bitmap.
    always_comb
    begin
        row_ok   = !row_index[15]
                   && (row_index[14:0] < 15'(CAP))
                   && (row_index[14:0] < 15'(rows_in_use));
        is_entry = (kind inside {scbp_pkg::KIND_ENTRY, scbp_pkg::KIND_ENTRY_CLOSE}) && row_ok;
        is_close = (kind inside {scbp_pkg::KIND_ENTRY_CLOSE, scbp_pkg::KIND_CLOSE});
        prod     = PROD_W'(row_index[ROW_W-1:0]) * PROD_W'(RECIP);
    end

    // The first stage moves on whenever the queue can take its command.
    assign advance  = !s1_valid_reg || !queue_full;
    assign in_ready = advance;
    assign accept   = in_valid && in_ready;
    assign push     = s1_valid_reg && !queue_full;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (advance)
        begin
            s1_valid_next = accept && (is_entry || is_close);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Quotient estimate by reciprocal; it is exact or one short.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_entry_reg <= is_entry;
            s1_close_reg <= is_close;
            s1_row_reg   <= row_index[ROW_W-1:0];
            s1_quot_reg  <= prod[RECIP_SHIFT +: WW];
        end
    end

    // Correct the quotient once and form the bit position.
    always_comb
    begin
        rem_raw  = (ROW_W + 1)'(s1_row_reg) - (ROW_W + 1)'(s1_quot_reg * WORD_BITS);
        rem_over = (rem_raw >= (ROW_W + 1)'(WORD_BITS));
        word_fix = rem_over ? s1_quot_reg + 1'b1 : s1_quot_reg;
        bit_fix  = rem_over ? rem_raw - (ROW_W + 1)'(WORD_BITS) : rem_raw;

        push_cmd.entry   = s1_entry_reg;
        push_cmd.close   = s1_close_reg;
        push_cmd.word    = scbp_pkg::POS_W'(word_fix);
        push_cmd.bit_pos = scbp_pkg::POS_W'(bit_fix[BW-1:0]);
    end

endmodule

### rtl/scbp_back.sv
`timescale 1ns / 1ps

module scbp_back #(
    parameter int WORD_BITS = scbp_pkg::WORD_BITS_DEF,
    parameter int MAX_WORDS = scbp_pkg::MAX_WORDS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    input  scbp_pkg::cmd_t                cmd,
    output logic                          cmd_pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          word_valid,
    output logic [scbp_pkg::POS_W-1:0]    word_position,
    output logic [scbp_pkg::DATA_W-1:0]   word_data,
    output logic [scbp_pkg::COUNT_W-1:0]  word_total,
    output logic                          last
);

    localparam int WW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int BW = $clog2(WORD_BITS);
    localparam int CW = scbp_pkg::COUNT_W;

    scbp_pkg::state_t      state_reg;
    scbp_pkg::state_t      state_next;

    // Bitmap memory and one valid bit per word.
    logic [WORD_BITS-1:0]  bitmap_mem [MAX_WORDS];
    logic [WORD_BITS-1:0]  rd_data_reg;
    logic [MAX_WORDS-1:0]  word_ok_reg;
    logic [MAX_WORDS-1:0]  word_ok_next;
    logic                  rd_en;
    logic [WW-1:0]         rd_addr;
    logic                  wr_en;
    logic [WW-1:0]         wr_addr;
    logic [WORD_BITS-1:0]  wr_data;
    logic [WORD_BITS-1:0]  old_word;

    // Read-modify-write stage and write forwarding.
    logic                  pend_valid_reg;
    logic                  pend_valid_next;
    logic [WW-1:0]         pend_word_reg;
    logic [BW-1:0]         pend_bit_reg;
    logic                  fwd_valid_reg;
    logic [WW-1:0]         fwd_word_reg;
    logic [WORD_BITS-1:0]  fwd_data_reg;

    logic [CW-1:0]         used_reg;
    logic [CW-1:0]         used_next;
    logic [CW-1:0]         entry_count;
    logic [CW-1:0]         drain_idx_reg;
    logic [CW-1:0]         drain_idx_next;
    logic                  drain_last;

    // Output register.
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic                        out_load;
    logic                        out_word_valid_reg;
    logic [scbp_pkg::POS_W-1:0]  out_pos_reg;
    logic [scbp_pkg::DATA_W-1:0] out_data_reg;
    logic [CW-1:0]               out_count_reg;
    logic                        out_last_reg;
    logic                        out_word_valid_next;
    logic [scbp_pkg::POS_W-1:0]  out_pos_next;
    logic [scbp_pkg::DATA_W-1:0] out_data_next;
    logic [CW-1:0]               out_count_next;
    logic                        out_last_next;
    logic                        finish;

    assign out_load    = !out_valid_reg || out_ready;
    assign cmd_pop     = (state_reg == scbp_pkg::ST_RUN) && cmd_valid;
    assign entry_count = CW'(cmd.word[WW-1:0]) + 1'b1;
    assign drain_last  = ((drain_idx_reg + 1'b1) == used_reg);

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            scbp_pkg::ST_RUN:
            begin
                if (cmd_pop && cmd.close)
                begin
                    state_next = scbp_pkg::ST_CLOSE;
                end
            end
            scbp_pkg::ST_CLOSE:
            begin
                if (!pend_valid_reg)
                begin
                    if (used_reg != '0)
                    begin
                        state_next = scbp_pkg::ST_DRAIN;
                    end
                    else if (out_load)
                    begin
                        state_next = scbp_pkg::ST_RUN;
                    end
                end
            end
            scbp_pkg::ST_DRAIN:
            begin
                if (out_load && drain_last)
                begin
                    state_next = scbp_pkg::ST_RUN;
                end
            end
            default:
            begin
                state_next = scbp_pkg::ST_RUN;
            end
        endcase
    end

    // Read-modify-write of one bitmap word, forwarding the last write.
    always_comb
    begin
        if (fwd_valid_reg && (fwd_word_reg == pend_word_reg))
        begin
            old_word = fwd_data_reg;
        end
        else if (word_ok_reg[pend_word_reg])
        begin
            old_word = rd_data_reg;
        end
        else
        begin
            old_word = '0;
        end
        wr_en   = pend_valid_reg;
        wr_addr = pend_word_reg;
        wr_data = old_word | ({{(WORD_BITS - 1){1'b0}}, 1'b1} << pend_bit_reg);
    end

    // Control and datapath outputs of each state.
    always_comb
    begin
        rd_en               = 1'b0;
        rd_addr             = '0;
        pend_valid_next     = 1'b0;
        used_next           = used_reg;
        drain_idx_next      = drain_idx_reg;
        finish              = 1'b0;
        out_valid_next      = out_valid_reg && !out_ready;
        out_word_valid_next = out_word_valid_reg;
        out_pos_next        = out_pos_reg;
        out_data_next       = out_data_reg;
        out_count_next      = out_count_reg;
        out_last_next       = out_last_reg;
        case (state_reg)
            scbp_pkg::ST_RUN:
            begin
                if (cmd_pop && cmd.entry)
                begin
                    rd_en           = 1'b1;
                    rd_addr         = cmd.word[WW-1:0];
                    pend_valid_next = 1'b1;
                    if (entry_count > used_reg)
                    begin
                        used_next = entry_count;
                    end
                end
            end
            scbp_pkg::ST_CLOSE:
            begin
                if (!pend_valid_reg)
                begin
                    if (used_reg != '0)
                    begin
                        rd_en          = 1'b1;
                        rd_addr        = '0;
                        drain_idx_next = '0;
                    end
                    else if (out_load)
                    begin
                        // Empty column: a single marker result.
                        out_valid_next      = 1'b1;
                        out_word_valid_next = 1'b0;
                        out_pos_next        = '0;
                        out_data_next       = '0;
                        out_count_next      = '0;
                        out_last_next       = 1'b1;
                    end
                end
            end
            scbp_pkg::ST_DRAIN:
            begin
                if (out_load)
                begin
                    out_valid_next      = 1'b1;
                    out_word_valid_next = 1'b1;
                    out_pos_next        = scbp_pkg::POS_W'(drain_idx_reg);
                    out_data_next       = word_ok_reg[drain_idx_reg[WW-1:0]]
                                          ? scbp_pkg::DATA_W'(rd_data_reg) : '0;
                    out_count_next      = used_reg;
                    out_last_next       = drain_last;
                    if (drain_last)
                    begin
                        finish    = 1'b1;
                        used_next = '0;
                    end
                    else
                    begin
                        drain_idx_next = drain_idx_reg + 1'b1;
                        rd_en          = 1'b1;
                        rd_addr        = drain_idx_next[WW-1:0];
                    end
                end
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    // Word valid bits: set on a write, all cleared when a column is done.
    always_comb
    begin
        word_ok_next = word_ok_reg;
        if (finish)
        begin
            word_ok_next = '0;
        end
        else if (wr_en)
        begin
            word_ok_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= scbp_pkg::ST_RUN;
            pend_valid_reg <= 1'b0;
            fwd_valid_reg  <= 1'b0;
            used_reg       <= '0;
            drain_idx_reg  <= '0;
            word_ok_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            fwd_valid_reg  <= wr_en;
            used_reg       <= used_next;
            drain_idx_reg  <= drain_idx_next;
            word_ok_reg    <= word_ok_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd_pop && cmd.entry)
        begin
            pend_word_reg <= cmd.word[WW-1:0];
            pend_bit_reg  <= cmd.bit_pos[BW-1:0];
        end
        fwd_word_reg       <= wr_addr;
        fwd_data_reg       <= wr_data;
        out_word_valid_reg <= out_word_valid_next;
        out_pos_reg        <= out_pos_next;
        out_data_reg       <= out_data_next;
        out_count_reg      <= out_count_next;
        out_last_reg       <= out_last_next;
    end

    // Bitmap memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            bitmap_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= bitmap_mem[rd_addr];
        end
    end

    assign out_valid     = out_valid_reg;
    assign word_valid    = out_word_valid_reg;
    assign word_position = out_pos_reg;
    assign word_data     = out_data_reg;
    assign word_total    = out_count_reg;
    assign last          = out_last_reg;

endmodule

### rtl/sparse_column_bit_packer.sv
`timescale 1ns / 1ps

// Channel     Direction  Transaction
// s_axis      in         tuser = kind, tdata = row_index
// m_axis      out        tuser = word_valid, tdata = position/data/count, tlast = last
// APB         in/out     register rows_in_use at byte address 0
//
// Entries are taken one per cycle while no close or drain is in progress; each is a
// read-modify-write of the bitmap memory with forwarding between neighbors. A close
// waits for a pending write, issues the first read, then drains the column's words at
// one per cycle while results are taken (one result for an empty column).
// A four-entry command queue and the front register absorb input during a drain;
// when both are full the input stalls. Reset is asynchronous and clears control state.
module sparse_column_bit_packer #(
    parameter int WORD_BITS = scbp_pkg::WORD_BITS_DEF,
    parameter int MAX_WORDS = scbp_pkg::MAX_WORDS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] row_index
    input  logic [1:0]  s_axis_tuser,   // [1:0] kind

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // [5:0] position, [69:6] data, [76:70] count
    output logic        m_axis_tuser,   // [0] word_valid
    output logic        m_axis_tlast,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [scbp_pkg::ROWS_W-1:0]   rows_in_use_reg;
    logic                          q_push;
    scbp_pkg::cmd_t                q_push_cmd;
    logic                          q_full;
    logic                          q_pop;
    scbp_pkg::cmd_t                q_pop_cmd;
    logic                          q_nonempty;
    logic                          word_valid;
    logic [scbp_pkg::POS_W-1:0]    word_position;
    logic [scbp_pkg::DATA_W-1:0]   word_data;
    logic [scbp_pkg::COUNT_W-1:0]  word_total;

    // Configuration register.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == scbp_pkg::REG_ROWS_IN_USE)
                    ? 32'(rows_in_use_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_in_use_reg <= '0;
        end
        else if (psel && penable && pwrite && pready
                 && (paddr[2] == scbp_pkg::REG_ROWS_IN_USE))
        begin
            rows_in_use_reg <= pwdata[scbp_pkg::ROWS_W-1:0];
        end
    end

    // Front: accept and classify items.
    scbp_front #(
        .WORD_BITS (WORD_BITS),
        .MAX_WORDS (MAX_WORDS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .rows_in_use (rows_in_use_reg),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .kind        (s_axis_tuser),
        .row_index   (s_axis_tdata),
        .push        (q_push),
        .push_cmd    (q_push_cmd),
        .queue_full  (q_full)
    );

    // Command queue between the two sides.
    scbp_queue #(
        .DEPTH (scbp_pkg::QUEUE_DEPTH_DEF)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .pop_cmd  (q_pop_cmd),
        .nonempty (q_nonempty)
    );

    // Back: bitmap memory and column drain.
    scbp_back #(
        .WORD_BITS (WORD_BITS),
        .MAX_WORDS (MAX_WORDS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (q_nonempty),
        .cmd           (q_pop_cmd),
        .cmd_pop       (q_pop),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .word_valid    (word_valid),
        .word_position (word_position),
        .word_data     (word_data),
        .word_total    (word_total),
        .last          (m_axis_tlast)
    );

    // Result packing.
    assign m_axis_tdata = {3'b000, word_total, word_data, word_position};
    assign m_axis_tuser = word_valid;

endmodule
